>>> hw/rtl/vefe_pkg.sv
package vefe_pkg;

  typedef struct packed {
    logic [3:0] block_type;
    logic [3:0] west_edge_block;
    logic [3:0] north_edge_block;
    logic       chunk_start;
  } voxel_t;

  typedef struct packed {
    logic [3:0] face_x;
    logic [6:0] face_y;
    logic [3:0] face_z;
    logic [2:0] direction;
    logic [3:0] face_block;
    logic [3:0] light_level;
    logic       last_face;
  } face_t;

  // one classified voxel waiting for its faces to go out
  typedef struct packed {
    logic [3:0]      x;
    logic [6:0]      y;
    logic [3:0]      z;
    logic            back;
    logic [2:0]      face_en;
    logic [2:0][3:0] face_blk;
  } job_t;

  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam logic [15:0] SOLID_MASK_RST = 16'hFFFE;

  localparam logic [2:0] XFRONT_CODE = 3'd0;
  localparam logic [2:0] XBACK_CODE  = 3'd1;
  localparam logic [2:0] YFRONT_CODE = 3'd2;
  localparam logic [2:0] YBACK_CODE  = 3'd3;
  localparam logic [2:0] ZFRONT_CODE = 3'd4;
  localparam logic [2:0] ZBACK_CODE  = 3'd5;

  localparam logic [3:0] LIGHT_X_FRONT = 4'd13;
  localparam logic [3:0] LIGHT_X_BACK  = 4'd9;
  localparam logic [3:0] LIGHT_Y_FRONT = 4'd15;
  localparam logic [3:0] LIGHT_Y_BACK  = 4'd5;
  localparam logic [3:0] LIGHT_Z_FRONT = 4'd11;
  localparam logic [3:0] LIGHT_Z_BACK  = 4'd7;

  function automatic logic [3:0] light_of(logic [2:0] dir);
    logic [3:0] lvl;
    case (dir)
      XFRONT_CODE: lvl = LIGHT_X_FRONT;
      XBACK_CODE:  lvl = LIGHT_X_BACK;
      YFRONT_CODE: lvl = LIGHT_Y_FRONT;
      YBACK_CODE:  lvl = LIGHT_Y_BACK;
      ZFRONT_CODE: lvl = LIGHT_Z_FRONT;
      ZBACK_CODE:  lvl = LIGHT_Z_BACK;
      default:     lvl = 4'd0;
    endcase
    return lvl;
  endfunction

endpackage

>>> hw/rtl/vefe_ram.sv
module vefe_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/vefe_front.sv
module vefe_front #(
  parameter int unsigned CHUNK_SIDE = 16,
  parameter int unsigned CHUNK_TALL = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  vefe_pkg::voxel_t                   voxel_i,
  output logic                               full_o,
  input  logic [15:0]                        solid_mask_i,
  input  logic [vefe_pkg::JOB_CNT_W-1:0]     job_cnt_i,
  output logic                               job_valid_o,
  output vefe_pkg::job_t                     job_o
);

  import vefe_pkg::*;

  localparam int unsigned SW    = $clog2(CHUNK_SIDE);
  localparam int unsigned TW    = $clog2(CHUNK_TALL);
  localparam int unsigned DEPTH = CHUNK_SIDE * CHUNK_TALL;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef struct packed {
    logic [3:0] cur;
    logic [3:0] west;
    logic [3:0] prev_y;
    logic [3:0] prev_z;
    logic [3:0] x;
    logic [6:0] y;
    logic [3:0] z;
    logic       x0;
    logic       ypos;
  } stage_t;

  logic                       accept;
  logic [SW-1:0]              x_q, x_d, x_eff;
  logic [TW-1:0]              y_q, y_d, y_eff;
  logic [SW-1:0]              z_q, z_d, z_eff;
  logic [AW-1:0]              adr_q, adr_d, adr_eff;
  logic [3:0]                 prior_z_q;
  logic [CHUNK_SIDE-1:0][3:0] line_q;
  logic                       s1_valid_q;
  stage_t                     s1_q, s1_d;
  logic [3:0]                 ram_rdata;
  logic [3:0]                 prev_x;
  logic                       cs, sx, sy, sz;

  assign full_o = s1_valid_q ? (job_cnt_i >= JOB_CNT_W'(JOB_DEPTH - 1))
                             : (job_cnt_i >= JOB_CNT_W'(JOB_DEPTH));
  assign accept = push_i && !full_o;

  always_comb begin
    x_eff   = voxel_i.chunk_start ? '0 : x_q;
    y_eff   = voxel_i.chunk_start ? '0 : y_q;
    z_eff   = voxel_i.chunk_start ? '0 : z_q;
    adr_eff = voxel_i.chunk_start ? '0 : adr_q;

    x_d   = x_eff;
    y_d   = y_eff;
    z_d   = z_eff + SW'(1);
    adr_d = (adr_eff == AW'(DEPTH - 1)) ? '0 : adr_eff + AW'(1);
    if (z_eff == SW'(CHUNK_SIDE - 1)) begin
      z_d = '0;
      y_d = y_eff + TW'(1);
      if (y_eff == TW'(CHUNK_TALL - 1)) begin
        y_d = '0;
        x_d = (x_eff == SW'(CHUNK_SIDE - 1)) ? '0 : x_eff + SW'(1);
      end
    end

    s1_d.cur    = voxel_i.block_type;
    s1_d.west   = voxel_i.west_edge_block;
    s1_d.prev_y = line_q[CHUNK_SIDE-1];
    s1_d.prev_z = (z_eff == '0) ? voxel_i.north_edge_block : prior_z_q;
    s1_d.x      = 4'(x_eff);
    s1_d.y      = 7'(y_eff);
    s1_d.z      = 4'(z_eff);
    s1_d.x0     = (x_eff == '0);
    s1_d.ypos   = (y_eff != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      z_q        <= '0;
      adr_q      <= '0;
      prior_z_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        x_q       <= x_d;
        y_q       <= y_d;
        z_q       <= z_d;
        adr_q     <= adr_d;
        prior_z_q <= voxel_i.block_type;
      end
    end
  end

  // previous row along y is the voxel exactly one row of z earlier
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q   <= s1_d;
      line_q <= {line_q[CHUNK_SIDE-2:0], voxel_i.block_type};
    end
  end

  vefe_ram #(
    .WIDTH(4),
    .DEPTH(DEPTH)
  ) u_slice (
    .clk_i  (clk_i),
    .we_i   (accept),
    .addr_i (adr_eff),
    .wdata_i(voxel_i.block_type),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    prev_x = s1_q.x0 ? s1_q.west : ram_rdata;
    cs     = solid_mask_i[s1_q.cur];
    sx     = solid_mask_i[prev_x];
    sy     = solid_mask_i[s1_q.prev_y];
    sz     = solid_mask_i[s1_q.prev_z];

    job_o.x           = s1_q.x;
    job_o.y           = s1_q.y;
    job_o.z           = s1_q.z;
    job_o.back        = cs;
    job_o.face_en[0]  = cs ^ sx;
    job_o.face_en[1]  = s1_q.ypos && (cs ^ sy);
    job_o.face_en[2]  = cs ^ sz;
    job_o.face_blk[0] = cs ? s1_q.cur : prev_x;
    job_o.face_blk[1] = cs ? s1_q.cur : s1_q.prev_y;
    job_o.face_blk[2] = cs ? s1_q.cur : s1_q.prev_z;
  end

  // voxels with no exposed face are dropped here
  assign job_valid_o = s1_valid_q && (|job_o.face_en);

endmodule

>>> hw/rtl/vefe_fifo.sv
module vefe_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_valid_i,
  input  vefe_pkg::job_t                 wr_data_i,
  input  logic                           rd_pop_i,
  output logic                           rd_valid_o,
  output vefe_pkg::job_t                 rd_data_o,
  output logic [vefe_pkg::JOB_CNT_W-1:0] cnt_o
);

  import vefe_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop = rd_pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (wr_valid_i && !do_pop) begin
      cnt_d = cnt_q + JOB_CNT_W'(1);
    end else if (!wr_valid_i && do_pop) begin
      cnt_d = cnt_q - JOB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign cnt_o      = cnt_q;

endmodule

>>> hw/rtl/vefe_back.sv
module vefe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  vefe_pkg::job_t    job_i,
  output logic              job_pop_o,
  output vefe_pkg::face_t   face_o,
  output logic              empty,
  input  logic              pop
);

  import vefe_pkg::*;

  logic [2:0] done_q, done_d;
  logic [2:0] rem, pick;
  logic       more;
  logic       load;
  logic       out_valid_q;
  face_t      face_q, face_d;

  assign load = job_valid_i && (!out_valid_q || pop);

  always_comb begin
    rem  = job_i.face_en & ~done_q;
    pick = rem & (~rem + 3'd1);
    more = |(rem & ~pick);

    face_d.direction  = job_i.back ? ZBACK_CODE : ZFRONT_CODE;
    face_d.face_block = job_i.face_blk[2];
    if (pick[0]) begin
      face_d.direction  = job_i.back ? XBACK_CODE : XFRONT_CODE;
      face_d.face_block = job_i.face_blk[0];
    end else if (pick[1]) begin
      face_d.direction  = job_i.back ? YBACK_CODE : YFRONT_CODE;
      face_d.face_block = job_i.face_blk[1];
    end
    face_d.face_x      = job_i.x;
    face_d.face_y      = job_i.y;
    face_d.face_z      = job_i.z;
    face_d.light_level = light_of(face_d.direction);
    face_d.last_face   = !more;

    done_d = done_q;
    if (load) begin
      done_d = more ? (done_q | pick) : 3'b000;
    end
  end

  assign job_pop_o = load && !more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      face_q <= face_d;
    end
  end

  assign face_o = face_q;
  assign empty  = !out_valid_q;

endmodule

>>> hw/rtl/voxel_exposed_face_extractor_core.sv
// path: a voxel goes through the stage-one register, job queue and face register
// throughput: one voxel per cycle in while full is low, one face record per cycle
//   out while pop is high; a voxel's n exposed faces (up to 3) give n records, and a
//   four-entry job queue between classifier and face emitter absorbs bursts
// reset: counters, previous-z type and solid mask (0xFFFE) reset at once;
//   the slice memory is not cleared and needs no clearing pass
module voxel_exposed_face_extractor_core #(
  parameter int unsigned CHUNK_SIDE = 16,
  parameter int unsigned CHUNK_TALL = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  vefe_pkg::voxel_t  voxel_i,
  output logic              empty,
  input  logic              pop,
  output vefe_pkg::face_t   face_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  import vefe_pkg::*;

  logic [15:0]          solid_mask_q;
  logic                 job_wr;
  job_t                 job_wdata;
  logic                 job_valid;
  job_t                 job_head;
  logic                 job_pop;
  logic [JOB_CNT_W-1:0] job_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_mask_q <= SOLID_MASK_RST;
    end else if (cfg_we_i) begin
      solid_mask_q <= cfg_wdata_i;
    end
  end

  vefe_front #(
    .CHUNK_SIDE(CHUNK_SIDE),
    .CHUNK_TALL(CHUNK_TALL)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .voxel_i     (voxel_i),
    .full_o      (full),
    .solid_mask_i(solid_mask_q),
    .job_cnt_i   (job_cnt),
    .job_valid_o (job_wr),
    .job_o       (job_wdata)
  );

  vefe_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(job_wr),
    .wr_data_i (job_wdata),
    .rd_pop_i  (job_pop),
    .rd_valid_o(job_valid),
    .rd_data_o (job_head),
    .cnt_o     (job_cnt)
  );

  vefe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .face_o     (face_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

>>> test/tb_voxel_exposed_face_extractor_core.sv
`timescale 1ns / 1ps

module tb_voxel_exposed_face_extractor_core;
  import vefe_pkg::*;

  localparam int unsigned SIDE          = 16;
  localparam int unsigned TALL          = 128;
  localparam int unsigned SLICE_CELLS   = SIDE * TALL;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 40000;

  // predicts the face records of each voxel and matches them in order
  class face_tracker;
    face_t       pending_faces[$];
    logic [15:0] solid_mask;
    logic [3:0]  slice_mem [SLICE_CELLS];
    logic [3:0]  prev_z_type;
    int unsigned x_pos;
    int unsigned y_pos;
    int unsigned z_pos;
    int unsigned mismatches;

    function new();
      solid_mask  = SOLID_MASK_RST;
      prev_z_type = 4'd0;
      x_pos       = 0;
      y_pos       = 0;
      z_pos       = 0;
      mismatches  = 0;
      foreach (slice_mem[i]) slice_mem[i] = 4'd0;
    endfunction

    function void queue_face(logic [2:0] dir, logic [3:0] blk);
      face_t f;
      f.face_x     = x_pos[3:0];
      f.face_y     = y_pos[6:0];
      f.face_z     = z_pos[3:0];
      f.direction  = dir;
      f.face_block = blk;
      case (dir)
        XFRONT_CODE: f.light_level = LIGHT_X_FRONT;
        XBACK_CODE:  f.light_level = LIGHT_X_BACK;
        YFRONT_CODE: f.light_level = LIGHT_Y_FRONT;
        YBACK_CODE:  f.light_level = LIGHT_Y_BACK;
        ZFRONT_CODE: f.light_level = LIGHT_Z_FRONT;
        default:     f.light_level = LIGHT_Z_BACK;
      endcase
      f.last_face = 1'b0;
      pending_faces.push_back(f);
    endfunction

    function void take_voxel(voxel_t v);
      logic [3:0]  cur;
      logic [3:0]  nb_x;
      logic [3:0]  nb_y;
      logic [3:0]  nb_z;
      int unsigned slot;
      int unsigned before_cnt;
      face_t       tail;
      if (v.chunk_start) begin
        x_pos = 0;
        y_pos = 0;
        z_pos = 0;
      end
      slot       = y_pos * SIDE + z_pos;
      cur        = v.block_type;
      nb_x       = (x_pos == 0) ? v.west_edge_block : slice_mem[slot];
      nb_y       = (y_pos > 0) ? slice_mem[slot - SIDE] : 4'd0;
      nb_z       = (z_pos == 0) ? v.north_edge_block : prev_z_type;
      before_cnt = pending_faces.size();
      if (solid_mask[cur]) begin
        if (!solid_mask[nb_x]) queue_face(XBACK_CODE, cur);
        if (y_pos > 0 && !solid_mask[nb_y]) queue_face(YBACK_CODE, cur);
        if (!solid_mask[nb_z]) queue_face(ZBACK_CODE, cur);
      end else begin
        if (solid_mask[nb_x]) queue_face(XFRONT_CODE, nb_x);
        if (y_pos > 0 && solid_mask[nb_y]) queue_face(YFRONT_CODE, nb_y);
        if (solid_mask[nb_z]) queue_face(ZFRONT_CODE, nb_z);
      end
      if (pending_faces.size() > before_cnt) begin
        tail = pending_faces.pop_back();
        tail.last_face = 1'b1;
        pending_faces.push_back(tail);
      end
      slice_mem[slot] = cur;
      prev_z_type     = cur;
      z_pos++;
      if (z_pos >= SIDE) begin
        z_pos = 0;
        y_pos++;
        if (y_pos >= TALL) begin
          y_pos = 0;
          x_pos++;
          if (x_pos >= SIDE) x_pos = 0;
        end
      end
    endfunction

    function void check_face(face_t got);
      face_t want;
      if (pending_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("face record with none expected: x=%0d y=%0d z=%0d dir=%0d blk=%0d",
                   got.face_x, got.face_y, got.face_z, got.direction, got.face_block);
        return;
      end
      want = pending_faces.pop_front();
      if (got.face_x !== want.face_x || got.face_y !== want.face_y ||
          got.face_z !== want.face_z || got.direction !== want.direction ||
          got.face_block !== want.face_block || got.light_level !== want.light_level ||
          got.last_face !== want.last_face) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("face mismatch: expected x=%0d y=%0d z=%0d dir=%0d blk=%0d light=%0d last=%0d",
                   want.face_x, want.face_y, want.face_z, want.direction, want.face_block,
                   want.light_level, want.last_face);
          $display("               actual   x=%0d y=%0d z=%0d dir=%0d blk=%0d light=%0d last=%0d",
                   got.face_x, got.face_y, got.face_z, got.direction, got.face_block,
                   got.light_level, got.last_face);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  voxel_t      voxel_i     = '0;
  logic        empty;
  logic        pop         = 1'b0;
  face_t       face_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;
  logic [3:0]  run_block     = 4'd0;
  face_tracker tracker;

  voxel_exposed_face_extractor_core #(
    .CHUNK_SIDE(SIDE),
    .CHUNK_TALL(TALL)
  ) dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .voxel_i,
    .empty,
    .pop,
    .face_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    pop = ($urandom_range(99) >= recv_idle_pct);
  end

  // transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) tracker.check_face(face_o);
      if (push && !full) tracker.take_voxel(voxel_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic voxel_t voxel_of(input logic [3:0] blk, input logic [3:0] west,
                                      input logic [3:0] north, input logic start);
    voxel_t v;
    v.block_type       = blk;
    v.west_edge_block  = west;
    v.north_edge_block = north;
    v.chunk_start      = start;
    return v;
  endfunction

  // types come in runs along z, like real terrain
  function automatic logic [3:0] next_block();
    if ($urandom_range(3) == 0) run_block = 4'($urandom_range(15));
    return run_block;
  endfunction

  task automatic send_voxel(input voxel_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    voxel_i = v;
    push    = 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic settle();
    push = 1'b0;
    while (tracker.pending_faces.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mask(input logic [15:0] mask);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mask;
    @(negedge clk_i);
    cfg_we_i           = 1'b0;
    tracker.solid_mask = mask;
  endtask

  // start_odds of 0 means no random restarts; stay_x0 keeps unwritten slots unread
  task automatic feed_voxels(input int unsigned count, input int unsigned start_odds,
                             input bit stay_x0, input bit restart_first);
    voxel_t v;
    for (int unsigned i = 0; i < count; i++) begin
      v.block_type       = next_block();
      v.west_edge_block  = 4'($urandom_range(15));
      v.north_edge_block = 4'($urandom_range(15));
      v.chunk_start      = (restart_first && i == 0) ||
                           (start_odds != 0 && $urandom_range(start_odds - 1) == 0) ||
                           (stay_x0 && tracker.y_pos >= TALL - 8);
      send_voxel(v);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // row y=0 against the edge inputs, reset mask
    send_voxel(voxel_of(4'd0, 4'd15, 4'd15, 1'b1));
    send_voxel(voxel_of(4'd15, 4'd0, 4'd0, 1'b0));
    send_voxel(voxel_of(4'd1, 4'd15, 4'd0, 1'b0));
    send_voxel(voxel_of(4'd0, 4'd0, 4'd0, 1'b0));
    for (int z = 4; z < 16; z++)
      send_voxel(voxel_of(4'(z * 5), z[0] ? 4'd15 : 4'd0, 4'd15, 1'b0));
    // row y=1: three back faces, then three front faces
    send_voxel(voxel_of(4'd15, 4'd0, 4'd0, 1'b0));
    send_voxel(voxel_of(4'd0, 4'd15, 4'd15, 1'b0));
    send_voxel(voxel_of(4'd0, 4'd0, 4'd0, 1'b0));
    // restart in the middle of a chunk
    send_voxel(voxel_of(4'd15, 4'd15, 4'd0, 1'b1));
    settle();

    send_idle_pct = 16;
    recv_idle_pct = 64;
    write_mask(16'($urandom));
    feed_voxels(100, 30, 1'b1, 1'b1);
    settle();

    send_idle_pct = 64;
    recv_idle_pct = 16;
    write_mask(16'hFFFF);
    feed_voxels(12, 30, 1'b1, 1'b0);
    settle();
    write_mask(16'h0000);
    feed_voxels(12, 30, 1'b1, 1'b0);
    settle();
    write_mask(16'($urandom));
    feed_voxels(90, 30, 1'b1, 1'b0);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mask(SOLID_MASK_RST);
    feed_voxels(30, 0, 1'b1, 1'b1);
    settle();

    if (tracker.mismatches == 0 && tracker.pending_faces.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/vefe_pkg.sv
hw/rtl/vefe_ram.sv
hw/rtl/vefe_front.sv
hw/rtl/vefe_fifo.sv
hw/rtl/vefe_back.sv
hw/rtl/voxel_exposed_face_extractor_core.sv
test/tb_voxel_exposed_face_extractor_core.sv
